// ----- hw/rtl/eegl_pkg.sv -----
// ----------------------------------------------------------------------------
// eegl_pkg: shared constants and types for the gcd / lcm block
// Operand widths, stream packing offsets and the divider request and
// response bundles.
// ----------------------------------------------------------------------------
package eegl_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int COEF_BITS    = OPERAND_BITS + 1;
  localparam int LCM_BITS     = 2 * OPERAND_BITS;
  localparam int PROD_BITS    = 2 * COEF_BITS;

  // quotient stack, deep enough for the longest remainder chain
  localparam int QSTACK_DEPTH = 128;
  localparam int QADDR_BITS   = $clog2(QSTACK_DEPTH);
  localparam int DEPTH_BITS   = $clog2(QSTACK_DEPTH + 1);

  // serial divider iteration counter
  localparam int DIV_CNT_BITS = $clog2(OPERAND_BITS + 1);

  // input beat packing
  localparam int A_LSB        = 0;
  localparam int B_LSB        = OPERAND_BITS;
  localparam int IN_DATA_BITS = ((2 * OPERAND_BITS + 7) / 8) * 8;

  // output beat packing
  localparam int GCD_LSB       = 0;
  localparam int X_LSB         = OPERAND_BITS;
  localparam int Y_LSB         = X_LSB + COEF_BITS;
  localparam int LCM_LSB       = Y_LSB + COEF_BITS;
  localparam int OUT_USED_BITS = LCM_LSB + LCM_BITS;
  localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;

  // request into the shared divider
  typedef struct packed {
    logic                    start;
    logic [OPERAND_BITS-1:0] dividend;
    logic [OPERAND_BITS-1:0] divisor;
  } div_req_t;

  // status back from the shared divider
  typedef struct packed {
    logic                    done;
    logic [OPERAND_BITS-1:0] quotient;
    logic [OPERAND_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- hw/rtl/eegl_ram.sv -----
// ----------------------------------------------------------------------------
// eegl_ram: generic single-port-write, registered-read memory
// One write and one read address per cycle; read data is registered and
// appears in the cycle after the address.
// ----------------------------------------------------------------------------
module eegl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/eegl_div.sv -----
// ----------------------------------------------------------------------------
// eegl_div: shared restoring divider
// One quotient bit per cycle; quotient and remainder hold after done
// until the next start.
// ----------------------------------------------------------------------------
module eegl_div
  import eegl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                    busy;
  logic                    done;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [OPERAND_BITS-1:0] quot;
  logic [OPERAND_BITS-1:0] rem;
  logic [OPERAND_BITS-1:0] dvs;
  logic [OPERAND_BITS:0]   trial;

  // trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem, quot[OPERAND_BITS-1]} - {1'b0, dvs};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_BITS'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      cnt  <= DIV_CNT_BITS'(OPERAND_BITS);
      quot <= req.dividend;
      rem  <= '0;
      dvs  <= req.divisor;
    end else if (busy) begin
      cnt <= cnt - DIV_CNT_BITS'(1);
      if (!trial[OPERAND_BITS]) begin
        rem  <= trial[OPERAND_BITS-1:0];
        quot <= {quot[OPERAND_BITS-2:0], 1'b1};
      end else begin
        rem  <= {rem[OPERAND_BITS-2:0], quot[OPERAND_BITS-1]};
        quot <= {quot[OPERAND_BITS-2:0], 1'b0};
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quot;
  assign rsp.remainder = rem;

  // a new division never lands on one in flight
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy)
    else $error("divider started while busy");

  // remainder always ends below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    done |-> rem < dvs)
    else $error("divider remainder not below divisor");

endmodule

// ----- hw/rtl/extended_euclid_gcd_lcm.sv -----
// ----------------------------------------------------------------------------
// extended_euclid_gcd_lcm: gcd, Bezout coefficients and lcm of two operands
// The remainder chain runs on the shared serial divider, then back-substitution
//   pops the quotient stack, then the lcm is formed as (a / gcd) * b; the lcm
//   division is skipped when the gcd is zero (both operands zero).
// One item is handled at a time; a new operand pair is taken only in idle.
// Reset: rst clears the sequencer and the output valid; the quotient stack
//   needs no clearing pass.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_lcm
  import eegl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // a_value, b_value
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // gcd_value, coef_x, coef_y, lcm_value
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  // both_zero
  output logic                     m_tuser
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DIV      = 9'b000000010,
    S_BACK_RD  = 9'b000000100,
    S_BACK_MUL = 9'b000001000,
    S_BACK_UPD = 9'b000010000,
    S_LCM      = 9'b000100000,
    S_LCM_DIV  = 9'b001000000,
    S_LCM_MUL  = 9'b010000000,
    S_OUT      = 9'b100000000
  } state_t;

  state_t                  state;
  logic [OPERAND_BITS-1:0] a_reg;
  logic [OPERAND_BITS-1:0] b_reg;
  logic [OPERAND_BITS-1:0] r0;
  logic [OPERAND_BITS-1:0] r1;
  logic [COEF_BITS-1:0]    x;
  logic [COEF_BITS-1:0]    y;
  logic [DEPTH_BITS-1:0]   depth;
  logic [PROD_BITS-1:0]    prod;

  logic [OPERAND_BITS-1:0] in_a;
  logic [OPERAND_BITS-1:0] in_b;
  logic                    accept;
  logic                    out_free;

  div_req_t                div_req;
  div_rsp_t                div_rsp;

  logic                    ram_we;
  logic [QADDR_BITS-1:0]   ram_raddr;
  logic [OPERAND_BITS-1:0] ram_rdata;

  logic [COEF_BITS-1:0]    mul_lhs;
  logic [COEF_BITS-1:0]    mul_rhs;
  logic [PROD_BITS-1:0]    mul_out;
  logic [OUT_DATA_BITS-1:0] out_word;

  // input unpacking and handshake
  assign in_a     = s_tdata[A_LSB +: OPERAND_BITS];
  assign in_b     = s_tdata[B_LSB +: OPERAND_BITS];
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // divider requests: first step, each following step, then a / gcd
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = r1;
    div_req.divisor  = div_rsp.remainder;
    unique case (state)
      S_IDLE: begin
        div_req.start    = accept && (in_b != '0);
        div_req.dividend = in_a;
        div_req.divisor  = in_b;
      end
      S_DIV: begin
        div_req.start = div_rsp.done && (div_rsp.remainder != '0);
      end
      S_LCM: begin
        div_req.start    = (r0 != '0);
        div_req.dividend = a_reg;
        div_req.divisor  = r0;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  eegl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // quotient stack
  assign ram_we    = (state == S_DIV) && div_rsp.done &&
                     (depth < DEPTH_BITS'(QSTACK_DEPTH));
  assign ram_raddr = QADDR_BITS'(depth - DEPTH_BITS'(1));

  eegl_ram #(
    .WIDTH (OPERAND_BITS),
    .DEPTH (QSTACK_DEPTH)
  ) u_qstack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (depth[QADDR_BITS-1:0]),
    .wdata (div_rsp.quotient),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier: q * y for back-substitution, (a / gcd) * b for lcm
  assign mul_lhs = (state == S_BACK_MUL) ? {1'b0, ram_rdata} : {1'b0, div_rsp.quotient};
  assign mul_rhs = (state == S_BACK_MUL) ? y : {1'b0, b_reg};
  assign mul_out = mul_lhs * mul_rhs;

  // result packing
  always_comb begin
    out_word                              = '0;
    out_word[GCD_LSB +: OPERAND_BITS]     = r0;
    out_word[X_LSB +: COEF_BITS]          = x;
    out_word[Y_LSB +: COEF_BITS]          = y;
    out_word[LCM_LSB +: LCM_BITS]         = prod[LCM_BITS-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // result beat raised on leaving the output state, dropped once taken
      if ((state == S_OUT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= (in_b != '0) ? S_DIV : S_LCM;
          end
        end
        S_DIV: begin
          if (div_rsp.done && div_rsp.remainder == '0) begin
            state <= S_BACK_RD;
          end
        end
        S_BACK_RD: begin
          state <= S_BACK_MUL;
        end
        S_BACK_MUL: begin
          state <= S_BACK_UPD;
        end
        S_BACK_UPD: begin
          state <= (depth != '0) ? S_BACK_MUL : S_LCM;
        end
        S_LCM: begin
          state <= (r0 != '0) ? S_LCM_DIV : S_OUT;
        end
        S_LCM_DIV: begin
          if (div_rsp.done) begin
            state <= S_LCM_MUL;
          end
        end
        S_LCM_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          a_reg <= in_a;
          b_reg <= in_b;
          r0    <= in_a;
          r1    <= in_b;
          x     <= COEF_BITS'(1);
          y     <= '0;
          depth <= '0;
        end
      end
      S_DIV: begin
        // one remainder step retired: push quotient, shift the pair
        if (div_rsp.done) begin
          r0 <= r1;
          r1 <= div_rsp.remainder;
          if (depth < DEPTH_BITS'(QSTACK_DEPTH)) begin
            depth <= depth + DEPTH_BITS'(1);
          end
        end
      end
      S_BACK_RD: begin
        depth <= depth - DEPTH_BITS'(1);
      end
      S_BACK_MUL: begin
        prod <= mul_out;
      end
      S_BACK_UPD: begin
        // x' = y, y' = x - q * y, next pop issued in the same cycle
        x <= y;
        y <= x - prod[COEF_BITS-1:0];
        if (depth != '0) begin
          depth <= depth - DEPTH_BITS'(1);
        end
      end
      S_LCM: begin
        if (r0 == '0) begin
          prod <= '0;
        end
      end
      S_LCM_MUL: begin
        prod <= mul_out;
      end
      S_OUT: begin
        if (out_free) begin
          m_tdata <= out_word;
          m_tuser <= (a_reg == '0) && (b_reg == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // the stack is never popped while empty
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_BACK_RD) |-> (depth != '0))
    else $error("quotient stack popped while empty");

  // the shared divider never sees a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

  // a result beat only appears after the output stage was reached
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result beat raised outside the output state");

endmodule

// ----- verif/gcd_lcm_checker.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_checker: scoreboard for the gcd / lcm block
// Watches both stream channels. For every operand beat taken on the slave
// side it works out gcd, Bezout coefficients, lcm and the both-zero flag.
// Each result beat is then compared field by field, oldest first. It hands
// the failure count and the number of outstanding results to the top.
// ----------------------------------------------------------------------------
module gcd_lcm_checker
  import eegl_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // a_value, b_value
  input  logic                     s_tvalid,
  input  logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // gcd_value, coef_x, coef_y, lcm_value
  input  logic                     m_tvalid,
  input  logic                     m_tready,
  input  logic [OUT_DATA_BITS-1:0] m_tdata,
  // both_zero
  input  logic                     m_tuser,
  output int unsigned              fail_count,
  output int unsigned              results_due
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    bit [OPERAND_BITS-1:0] gcd;
    bit [COEF_BITS-1:0]    x;
    bit [COEF_BITS-1:0]    y;
    bit [LCM_BITS-1:0]     lcm;
    bit                    both_zero;
  } gcd_result_t;

  gcd_result_t awaited_results[$];

  // euclid with quotient stack, then back-substitution; 64-bit wrap
  function automatic gcd_result_t solve_gcd(input bit [OPERAND_BITS-1:0] a,
                                            input bit [OPERAND_BITS-1:0] b);
    bit [63:0]   a64, b64, r0, r1, rem, x, y, nx, g, q;
    bit [63:0]   quots[$];
    gcd_result_t res;
    a64 = 64'(a);
    b64 = 64'(b);
    r0  = a64;
    r1  = b64;
    x   = 64'd1;
    y   = 64'd0;
    // remainder chain
    while (r1 != 0) begin
      quots.push_back(r0 / r1);
      rem = r0 % r1;
      r0  = r1;
      r1  = rem;
    end
    g = r0;
    // substitute back from the last step
    while (quots.size() != 0) begin
      q  = quots.pop_back();
      nx = y;
      y  = x - q * y;
      x  = nx;
    end
    res.gcd       = g[OPERAND_BITS-1:0];
    res.x         = x[COEF_BITS-1:0];
    res.y         = y[COEF_BITS-1:0];
    res.lcm       = (g == 0) ? '0 : LCM_BITS'((a64 / g) * b64);
    res.both_zero = (a == 0) && (b == 0);
    return res;
  endfunction

  task automatic compare_field(input string field, input bit [63:0] want,
                               input bit [63:0] got);
    if (want != got) begin
      if (fail_count < REPORT_LIMIT)
        $display("mismatch on %s: expected %0h, got %0h", field, want, got);
      fail_count++;
    end
  endtask

  // result side first, since a beat out never belongs to the beat taken with it
  always @(posedge clk) begin
    gcd_result_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count < REPORT_LIMIT)
            $display("unexpected result beat: %0h", m_tdata);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("gcd_value", 64'(want.gcd), 64'(m_tdata[GCD_LSB +: OPERAND_BITS]));
          compare_field("coef_x", 64'(want.x), 64'(m_tdata[X_LSB +: COEF_BITS]));
          compare_field("coef_y", 64'(want.y), 64'(m_tdata[Y_LSB +: COEF_BITS]));
          compare_field("lcm_value", 64'(want.lcm), 64'(m_tdata[LCM_LSB +: LCM_BITS]));
          compare_field("both_zero", 64'(want.both_zero), 64'(m_tuser));
        end
      end
      if (s_tvalid && s_tready)
        awaited_results.push_back(solve_gcd(s_tdata[A_LSB +: OPERAND_BITS],
                                            s_tdata[B_LSB +: OPERAND_BITS]));
      results_due <= awaited_results.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: regression for the gcd / lcm block
// Drives operand pairs into the block: a directed set of corner cases, then
// a random mix of full-range, small, shared-factor, one-zero, multiple,
// Fibonacci, bit-pattern and shifted operands. Random gaps on the operand
// stream and random back-pressure on the result stream. The checker
// predicts and compares; the top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import eegl_pkg::*;

  typedef logic [OPERAND_BITS-1:0] opnd_t;

  localparam int unsigned RANDOM_ITEMS   = 348;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned DRAIN_CYCLES   = 1700;
  localparam opnd_t       OPND_MAX       = '1;

  logic                     clk      = 1'b0;
  logic                     rst      = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata  = '0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tuser;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold  = 0;
  bit          calm        = 1'b0;
  opnd_t       fib_seq [0:46];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  extended_euclid_gcd_lcm u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  gcd_lcm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // mostly short gaps, a few long ones, none in calm stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(30, 120);
  endfunction

  function automatic opnd_t corner_operand();
    opnd_t v;
    v = opnd_t'(1);
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = opnd_t'(1);
      2: v = OPND_MAX;
      3: v = v << $urandom_range(0, OPERAND_BITS - 1);
      default: v = (v << $urandom_range(1, OPERAND_BITS - 1)) - 1'b1;
    endcase
    return v;
  endfunction

  // one operand beat, valid held high when no gap comes between beats
  task automatic push_operands(input opnd_t a, input opnd_t b);
    int unsigned             gap;
    logic [IN_DATA_BITS-1:0] beat;
    gap  = pick_gap();
    beat = '0;
    beat[A_LSB +: OPERAND_BITS] = a;
    beat[B_LSB +: OPERAND_BITS] = b;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // result back-pressure
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (m_tready && !calm) begin
      m_tready   <= 1'b0;
      ready_hold <= pick_gap();
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 300);
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    opnd_t       op_a, op_b, tmp;
    int unsigned kind, factor, k;
    fib_seq[0] = '0;
    fib_seq[1] = opnd_t'(1);
    for (int i = 2; i <= 46; i++) fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    push_operands('0, '0);                          // both zero
    push_operands(opnd_t'(12345), '0);              // b zero
    push_operands(OPND_MAX, '0);
    push_operands(opnd_t'(1), '0);
    push_operands('0, opnd_t'(77));                 // a zero, b nonzero
    push_operands('0, OPND_MAX);
    push_operands('0, opnd_t'(1));
    push_operands(OPND_MAX, OPND_MAX);              // equal operands
    push_operands(opnd_t'(1), opnd_t'(1));
    push_operands(OPND_MAX, opnd_t'(1));
    push_operands(opnd_t'(1), OPND_MAX);            // a below b
    push_operands(opnd_t'(2), opnd_t'(1));
    push_operands(fib_seq[46], fib_seq[45]);        // longest remainder chain
    push_operands(fib_seq[45], fib_seq[46]);
    push_operands(opnd_t'(240), opnd_t'(46));
    push_operands(opnd_t'(46), opnd_t'(240));
    push_operands(OPND_MAX, OPND_MAX - 1'b1);
    push_operands(opnd_t'(31'h4000_0000), opnd_t'(31'h6000_0000));
    push_operands(opnd_t'(2147483629), OPND_MAX);   // large coprime pair
    push_operands(opnd_t'(31'h4000_0000), OPND_MAX);
    push_operands(opnd_t'(31'h5555_5555), opnd_t'(31'h2aaa_aaaa));
    push_operands(opnd_t'(31'h2aaa_aaaa), opnd_t'(31'h5555_5555));

    // random mix
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 60 == 0) calm = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        op_a = opnd_t'($urandom);
        op_b = opnd_t'($urandom);
      end else if (kind < 50) begin
        // shared factor
        factor = $urandom_range(1, 65535);
        op_a   = opnd_t'(factor * $urandom_range(0, int'(OPND_MAX) / factor));
        op_b   = opnd_t'(factor * $urandom_range(0, int'(OPND_MAX) / factor));
      end else if (kind < 60) begin
        op_a = opnd_t'($urandom_range(0, 255));
        op_b = opnd_t'($urandom_range(0, 255));
      end else if (kind < 68) begin
        // one operand zero
        op_a = opnd_t'($urandom);
        op_b = '0;
        if ($urandom_range(0, 1) == 1) begin
          op_b = op_a;
          op_a = '0;
        end
      end else if (kind < 76) begin
        // a multiple of b
        factor = $urandom_range(1, 65535);
        op_b   = opnd_t'(factor);
        op_a   = opnd_t'(factor * $urandom_range(0, int'(OPND_MAX) / factor));
      end else if (kind < 84) begin
        // consecutive fibonacci numbers
        k    = $urandom_range(1, 46);
        op_a = fib_seq[k];
        op_b = fib_seq[k-1];
        if ($urandom_range(0, 1) == 1) begin
          tmp  = op_a;
          op_a = op_b;
          op_b = tmp;
        end
      end else if (kind < 92) begin
        op_a = corner_operand();
        op_b = corner_operand();
      end else begin
        // random magnitudes
        op_a = opnd_t'($urandom) >> $urandom_range(0, OPERAND_BITS - 1);
        op_b = opnd_t'($urandom) >> $urandom_range(0, OPERAND_BITS - 1);
      end
      push_operands(op_a, op_b);
    end
    s_tvalid <= 1'b0;
    calm = 1'b0;

    // let the checker count the last beat, drain, then watch for stray beats
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && results_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/eegl_pkg.sv
hw/rtl/eegl_ram.sv
hw/rtl/eegl_div.sv
hw/rtl/extended_euclid_gcd_lcm.sv
verif/gcd_lcm_checker.sv
verif/testbench.sv
